### rtl/gws_pkg.sv
// Shared constants, types and match function for the grid word search counter.
package gws_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WID_W      = $clog2(MAX_WIDTH + 1) + 1;
   localparam int CH_W       = 8;
   localparam int WORD_W     = 4 * CH_W;
   localparam int LINE_W     = 9;
   localparam int MATCH_W    = 4;
   localparam int TOTAL_W    = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [WORD_W-1:0]     WORD_RESET = 32'h5341_4D58;
   localparam logic [LINE_W-1:0]     LINE_RESET = 9'd256;
   localparam logic [1:0]            ROWS_FULL  = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_WORD_CHARS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_WIDTH = 2'd1;

   typedef struct packed {
      logic [CH_W-1:0]  ch;
      logic             first;
      logic [COL_W-1:0] col;
      logic             gate_h;
      logic             gate_v;
      logic             gate_dr;
      logic             gate_dl;
   } gws_cls_type;

   typedef struct packed {
      logic [MATCH_W-1:0] hit_count;
      logic [TOTAL_W-1:0] total;
   } gws_rsp_type;

   // forward and reverse reading of one four-cell segment, s0 first in raster order
   function automatic logic [1:0] seg_hits(input logic [WORD_W-1:0] word,
                                           input logic [CH_W-1:0] s0,
                                           input logic [CH_W-1:0] s1,
                                           input logic [CH_W-1:0] s2,
                                           input logic [CH_W-1:0] s3);
      logic fwd;
      logic rev;
      fwd = (s0 == word[7:0]) && (s1 == word[15:8]) &&
            (s2 == word[23:16]) && (s3 == word[31:24]);
      rev = (s3 == word[7:0]) && (s2 == word[15:8]) &&
            (s1 == word[23:16]) && (s0 == word[31:24]);
      return {1'b0, fwd} + {1'b0, rev};
   endfunction

endpackage

### rtl/gws_ram.sv
// Generic write-first RAM, one write port and two registered read ports.
module gws_ram #(
   parameter int DEPTH  = 256,
   parameter int DATA_W = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
      rd_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/gws_front.sv
// Front end: config registers, input handshake, grid position tracking and segment gates.
module gws_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gws_pkg::CH_W-1:0]         req_ch,
   input  logic                             req_first_of_grid,
   input  logic                             csr_wr_en,
   input  logic [gws_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [gws_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             clr_busy,
   input  logic                             room,
   output logic                             fire,
   output gws_pkg::gws_cls_type             cls,
   output logic [gws_pkg::WORD_W-1:0]       word_chars
);
   import gws_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [LINE_W-1:0] line_ff;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [1:0]        rows_ff;
   logic [1:0]        rows_in;

   logic [WID_W-1:0]  w_act;
   logic [COL_W-1:0]  col0;
   logic [1:0]        rows0;
   logic              wrap0;
   logic [COL_W-1:0]  c;
   logic [1:0]        rows1;
   logic [WID_W-1:0]  c_next;
   logic              wrap1;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= WORD_RESET;
         line_ff <= LINE_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_WORD_CHARS: word_ff <= csr_wdata[WORD_W-1:0];
            CSR_LINE_WIDTH: line_ff <= csr_wdata[LINE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(line_ff) < 32'd4) begin
         w_act = WID_W'(4);
      end else if (32'(line_ff) > 32'(MAX_WIDTH)) begin
         w_act = WID_W'(MAX_WIDTH);
      end else begin
         w_act = WID_W'(line_ff);
      end
   end

   always_comb begin
      col0   = req_first_of_grid ? '0 : col_ff;
      rows0  = req_first_of_grid ? '0 : rows_ff;
      wrap0  = WID_W'(col0) >= w_act;
      c      = wrap0 ? '0 : col0;
      rows1  = (wrap0 && rows0 != ROWS_FULL) ? rows0 + 2'd1 : rows0;
      c_next = WID_W'(c) + WID_W'(1);
      wrap1  = c_next >= w_act;
      col_in  = wrap1 ? '0 : c_next[COL_W-1:0];
      rows_in = (wrap1 && rows1 != ROWS_FULL) ? rows1 + 2'd1 : rows1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         rows_ff <= '0;
      end else if (fire) begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
      end
   end

   assign req_ready = !clr_busy && room;
   assign fire      = req_valid && req_ready;

   always_comb begin
      cls.ch      = req_ch;
      cls.first   = req_first_of_grid;
      cls.col     = c;
      cls.gate_h  = c >= COL_W'(3);
      cls.gate_v  = rows1 == ROWS_FULL;
      cls.gate_dr = (rows1 == ROWS_FULL) && (c >= COL_W'(3));
      cls.gate_dl = (rows1 == ROWS_FULL) && ((WID_W'(c) + WID_W'(3)) < w_act);
   end

   assign word_chars = word_ff;

endmodule

### rtl/gws_core.sv
// Back end: line stores, window registers, segment matching and running total.
module gws_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  gws_pkg::gws_cls_type        cls,
   input  logic [gws_pkg::WORD_W-1:0]  word_chars,
   output logic                        clr_busy,
   output logic                        inflight,
   output logic                        push,
   output gws_pkg::gws_rsp_type        push_data
);
   import gws_pkg::*;

   logic              s1_valid_ff;
   gws_cls_type       s1_ff;
   logic              clr_busy_ff;
   logic [COL_W-1:0]  clr_col_ff;
   logic [3*CH_W-1:0] recent_ff;
   logic [CH_W-1:0]   win1_ff;
   logic [2*CH_W-1:0] win2_ff;
   logic [3*CH_W-1:0] win3_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;

   logic              wr_en;
   logic [COL_W-1:0]  wr_addr;
   logic [CH_W-1:0]   a1, a2, a3;
   logic [CH_W-1:0]   d1, d2, d3;
   logic [CH_W-1:0]   wd1, wd2, wd3;
   logic [MATCH_W-1:0] hits;
   logic [1:0]        h_h, h_v, h_dr, h_dl;
   logic [TOTAL_W-1:0] base;
   logic [TOTAL_W:0]   sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_col_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_col_ff <= clr_col_ff + COL_W'(1);
         if (clr_col_ff == COL_W'(MAX_WIDTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= cls;
   end

   assign wr_en   = clr_busy_ff || s1_valid_ff;
   assign wr_addr = clr_busy_ff ? clr_col_ff : s1_ff.col;
   assign wd1     = clr_busy_ff ? '0 : s1_ff.ch;
   assign wd2     = clr_busy_ff ? '0 : a1;
   assign wd3     = clr_busy_ff ? '0 : a2;

   gws_ram #(.DEPTH(MAX_WIDTH), .DATA_W(CH_W)) u_row1 (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wd1),
      .rd_addr_a (cls.col),
      .rd_addr_b (cls.col + COL_W'(1)),
      .rd_data_a (a1),
      .rd_data_b (d1)
   );

   gws_ram #(.DEPTH(MAX_WIDTH), .DATA_W(CH_W)) u_row2 (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wd2),
      .rd_addr_a (cls.col),
      .rd_addr_b (cls.col + COL_W'(2)),
      .rd_data_a (a2),
      .rd_data_b (d2)
   );

   gws_ram #(.DEPTH(MAX_WIDTH), .DATA_W(CH_W)) u_row3 (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wd3),
      .rd_addr_a (cls.col),
      .rd_addr_b (cls.col + COL_W'(3)),
      .rd_data_a (a3),
      .rd_data_b (d3)
   );

   always_comb begin
      h_h  = s1_ff.gate_h ?
             seg_hits(word_chars, recent_ff[23:16], recent_ff[15:8], recent_ff[7:0], s1_ff.ch)
             : 2'd0;
      h_v  = s1_ff.gate_v ? seg_hits(word_chars, a3, a2, a1, s1_ff.ch) : 2'd0;
      h_dr = s1_ff.gate_dr ?
             seg_hits(word_chars, win3_ff[23:16], win2_ff[15:8], win1_ff, s1_ff.ch) : 2'd0;
      h_dl = s1_ff.gate_dl ? seg_hits(word_chars, d3, d2, d1, s1_ff.ch) : 2'd0;
      hits = MATCH_W'(h_h) + MATCH_W'(h_v) + MATCH_W'(h_dr) + MATCH_W'(h_dl);
      base = s1_ff.first ? '0 : total_ff;
      sum  = {1'b0, base} + (TOTAL_W + 1)'(hits);
      total_in = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         win1_ff   <= '0;
         win2_ff   <= '0;
         win3_ff   <= '0;
         total_ff  <= '0;
      end else if (s1_valid_ff) begin
         recent_ff <= {recent_ff[15:0], s1_ff.ch};
         win1_ff   <= a1;
         win2_ff   <= {win2_ff[7:0], a2};
         win3_ff   <= {win3_ff[15:0], a3};
         total_ff  <= total_in;
      end
   end

   assign clr_busy            = clr_busy_ff;
   assign inflight            = s1_valid_ff;
   assign push                = s1_valid_ff;
   assign push_data.hit_count = hits;
   assign push_data.total     = total_in;

endmodule

### rtl/gws_fifo.sv
// Result queue between the match pipeline and the response channel.
module gws_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  gws_pkg::gws_rsp_type              push_data,
   input  logic                              inflight,
   output logic                              room,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gws_pkg::MATCH_W-1:0]       rsp_matches_here,
   output logic [gws_pkg::TOTAL_W-1:0]       rsp_total_matches
);
   import gws_pkg::*;

   gws_rsp_type             entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic [FIFO_CNT_W-1:0]   count_in;
   logic                    pop;
   logic [FIFO_CNT_W:0]     reserved;

   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // one slot for the item in the match stage, one for the item being taken now
   assign reserved = {1'b0, count_ff} + (FIFO_CNT_W + 1)'(inflight);
   assign room     = reserved < (FIFO_CNT_W + 1)'(FIFO_DEPTH);

   assign rsp_valid         = count_ff != '0;
   assign rsp_matches_here  = entry_ff[rd_ptr_ff].hit_count;
   assign rsp_total_matches = entry_ff[rd_ptr_ff].total;

endmodule

### rtl/grid_word_search_counter.sv
// Top level: eight-direction four-letter word counter over a raster-order character grid.
//
//   channel | ports                                         | transfer
//   req     | req_valid req_ready req_ch req_first_of_grid  | valid && ready
//   rsp     | rsp_valid rsp_ready rsp_matches_here          | valid && ready
//           |   rsp_total_matches                           |
//   csr     | csr_wr_en csr_addr csr_wdata                  | csr_wr_en
//
// One character per cycle while req_ready is high; after its transfer a result is registered
// in the match stage, written into the queue and offered on rsp from then on.
// The three line stores are RAMs with two read ports, one store row per grid row.
// After reset a pass over all 256 columns clears the line stores; req_ready stays low meanwhile.
// A four-entry result queue absorbs rsp stalls; req_ready drops once it is reserved.
module grid_word_search_counter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gws_pkg::CH_W-1:0]         req_ch,
   input  logic                             req_first_of_grid,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gws_pkg::MATCH_W-1:0]      rsp_matches_here,
   output logic [gws_pkg::TOTAL_W-1:0]      rsp_total_matches,
   input  logic                             csr_wr_en,
   input  logic [gws_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [gws_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gws_pkg::*;

   logic              fire;
   gws_cls_type       cls;
   logic [WORD_W-1:0] word_chars;
   logic              clr_busy;
   logic              room;
   logic              inflight;
   logic              push;
   gws_rsp_type       push_data;

   gws_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_first_of_grid (req_first_of_grid),
      .csr_wr_en         (csr_wr_en),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .clr_busy          (clr_busy),
      .room              (room),
      .fire              (fire),
      .cls               (cls),
      .word_chars        (word_chars)
   );

   gws_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .cls        (cls),
      .word_chars (word_chars),
      .clr_busy   (clr_busy),
      .inflight   (inflight),
      .push       (push),
      .push_data  (push_data)
   );

   gws_fifo u_fifo (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .push_data         (push_data),
      .inflight          (inflight),
      .room              (room),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matches_here  (rsp_matches_here),
      .rsp_total_matches (rsp_total_matches)
   );

endmodule

### rtl/gws_checker.sv
// Port-level checks for the word search counter, bound to the top level.
module gws_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [gws_pkg::MATCH_W-1:0]      rsp_matches_here,
   input  logic [gws_pkg::TOTAL_W-1:0]      rsp_total_matches
);
   import gws_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matches_here)
                                 && $stable(rsp_total_matches))
      else $error("rsp payload changed while stalled");

   a_match_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_matches_here <= MATCH_W'(8))
      else $error("more than eight matches at one cell");

   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_matches >= TOTAL_W'(rsp_matches_here))
      else $error("running total below matches at this cell");

   a_clear_pass: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("req accepted or rsp shown during line store clear");

endmodule

bind grid_word_search_counter gws_checker u_gws_checker (.*);

### tb/gws_match_checker.sv
// Checker for grid_word_search_counter: tracks the grid cell by cell and checks every result.
module gws_match_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [gws_pkg::CH_W-1:0]       req_ch,
   input  logic                           req_first_of_grid,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [gws_pkg::MATCH_W-1:0]    rsp_matches_here,
   input  logic [gws_pkg::TOTAL_W-1:0]    rsp_total_matches,
   input  logic                           csr_wr_en,
   input  logic [gws_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [gws_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    mismatches,
   output int unsigned                    pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import gws_pkg::*;

   logic [WORD_W-1:0]  word_now;
   logic [LINE_W-1:0]  width_now;
   logic [CH_W-1:0]    rows_above [3][MAX_WIDTH];
   logic [3*CH_W-1:0]  row_tail;
   logic [CH_W-1:0]    diag_1;
   logic [CH_W-1:0]    diag_2 [2];
   logic [CH_W-1:0]    diag_3 [3];
   int unsigned        col_next;
   int unsigned        rows_done;
   logic [TOTAL_W-1:0] grid_total;
   gws_rsp_type        results_due [$];

   // a first, d last in raster order; both readings count
   function automatic int unsigned seg_count(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                             input logic [CH_W-1:0] c, input logic [CH_W-1:0] d);
      int unsigned n;
      n = 0;
      if ({d, c, b, a} == word_now) n++;
      if ({a, b, c, d} == word_now) n++;
      return n;
   endfunction

   task automatic count_cell(input logic [CH_W-1:0] char_in, input logic first);
      int unsigned        w;
      int unsigned        col;
      int unsigned        hits;
      logic [CH_W-1:0]    up1;
      logic [CH_W-1:0]    up2;
      logic [CH_W-1:0]    up3;
      logic [TOTAL_W:0]   sum;
      gws_rsp_type        due;
      w = (width_now < 4) ? 4 : (width_now > MAX_WIDTH) ? MAX_WIDTH : width_now;
      if (first) begin
         col_next = 0;
         rows_done = 0;
         grid_total = '0;
      end
      if (col_next >= w) begin
         col_next = 0;
         if (rows_done < 3) rows_done++;
      end
      col = col_next;
      up1 = rows_above[0][COL_W'(col)];
      up2 = rows_above[1][COL_W'(col)];
      up3 = rows_above[2][COL_W'(col)];
      hits = 0;
      if (col >= 3) hits += seg_count(row_tail[23:16], row_tail[15:8], row_tail[7:0], char_in);
      if (rows_done == 3) begin
         hits += seg_count(up3, up2, up1, char_in);
         if (col >= 3) hits += seg_count(diag_3[2], diag_2[1], diag_1, char_in);
         if (col + 3 < w)
            hits += seg_count(rows_above[2][COL_W'(col+3)], rows_above[1][COL_W'(col+2)],
                              rows_above[0][COL_W'(col+1)], char_in);
      end
      rows_above[2][COL_W'(col)] = up2;
      rows_above[1][COL_W'(col)] = up1;
      rows_above[0][COL_W'(col)] = char_in;
      diag_3[2] = diag_3[1];
      diag_3[1] = diag_3[0];
      diag_3[0] = up3;
      diag_2[1] = diag_2[0];
      diag_2[0] = up2;
      diag_1 = up1;
      row_tail = {row_tail[15:0], char_in};
      sum = {1'b0, grid_total} + (TOTAL_W + 1)'(hits);
      grid_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      col_next = col + 1;
      if (col_next >= w) begin
         col_next = 0;
         if (rows_done < 3) rows_done++;
      end
      due.hit_count = hits[MATCH_W-1:0];
      due.total = grid_total;
      results_due = {results_due, due};
   endtask

   always @(posedge clock) begin
      gws_rsp_type want;
      if (reset) begin
         word_now = WORD_RESET;
         width_now = LINE_RESET;
         foreach (rows_above[k, j]) rows_above[k][j] = '0;
         row_tail = '0;
         diag_1 = '0;
         diag_2 = '{default: '0};
         diag_3 = '{default: '0};
         col_next = 0;
         rows_done = 0;
         grid_total = '0;
         results_due.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t ns: result with nothing due: matches_here=%0d total_matches=%0d",
                           $time, rsp_matches_here, rsp_total_matches);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               if (want.hit_count !== rsp_matches_here || want.total !== rsp_total_matches) begin
                  if (mismatches < 10)
                     $display("%0t ns: matches_here exp %0d got %0d, total_matches exp %0d got %0d",
                              $time, want.hit_count, rsp_matches_here, want.total,
                              rsp_total_matches);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) count_cell(req_ch, req_first_of_grid);
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_WORD_CHARS: word_now = csr_wdata[WORD_W-1:0];
               CSR_LINE_WIDTH: width_now = csr_wdata[LINE_W-1:0];
               default: ;
            endcase
         end
      end
      pending <= results_due.size();
   end

endmodule

### tb/tb_grid_word_search_counter.sv
// Testbench top for grid_word_search_counter: grid stimulus, idling, register setup and verdict.
module tb_grid_word_search_counter;
   timeunit 1ns;
   timeprecision 1ps;
   import gws_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum int unsigned {PH_SMALL, PH_WIDE, PH_FULL} phase_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CH_W-1:0]       req_ch = '0;
   logic                  req_first_of_grid = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [MATCH_W-1:0]    rsp_matches_here;
   logic [TOTAL_W-1:0]    rsp_total_matches;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned       mismatches;
   int unsigned       pending;
   int unsigned       sent_count = 0;
   int unsigned       random_items = 0;
   int unsigned       burst_left = 0;
   bit                gapless = 1'b0;
   logic [WORD_W-1:0] cur_word = WORD_RESET;
   logic [LINE_W-1:0] cur_width = LINE_RESET;

   grid_word_search_counter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_first_of_grid (req_first_of_grid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matches_here  (rsp_matches_here),
      .rsp_total_matches (rsp_total_matches),
      .csr_wr_en         (csr_wr_en),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata)
   );

   gws_match_checker count_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_first_of_grid (req_first_of_grid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matches_here  (rsp_matches_here),
      .rsp_total_matches (rsp_total_matches),
      .csr_wr_en         (csr_wr_en),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** grid_word_search_counter: FAILED **");
      $finish;
   end

   task automatic send_cell(input logic [CH_W-1:0] char_in, input logic first);
      int unsigned gap;
      req_valid <= 1'b1;
      req_ch <= char_in;
      req_first_of_grid <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = gapless ? 0 : $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering and let every due result come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_regs(input logic [WORD_W-1:0] word_val, input logic [LINE_W-1:0] width_val,
                            input logic [1:0] mask, input bit spare);
      if (mask[0]) begin
         csr_wr_en <= 1'b1;
         csr_addr <= CSR_WORD_CHARS;
         csr_wdata <= word_val;
         @(posedge clock);
      end
      if (mask[1]) begin
         csr_wr_en <= 1'b1;
         csr_addr <= CSR_LINE_WIDTH;
         csr_wdata <= ($urandom & ~32'h1FF) | CSR_DATA_W'(width_val);
         @(posedge clock);
      end
      if (spare) begin
         csr_wr_en <= 1'b1;
         csr_addr <= $urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3;
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input phase_type shape);
      logic [CH_W-1:0]   alpha [5];
      logic [CH_W-1:0]   pick;
      logic [WORD_W-1:0] word_val;
      logic [LINE_W-1:0] width_val;
      logic [1:0]        mask;
      int unsigned       w_eff;
      int unsigned       n_cells;
      int unsigned       kind;
      bit                fresh;
      settle();
      kind = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) alpha[i] = CH_W'(8'h41 + $urandom_range(0, 3));
      case (kind)
         0: word_val = {alpha[3], alpha[2], alpha[1], alpha[0]};
         1: word_val = {4{alpha[0]}};
         2: word_val = {alpha[0], alpha[1], alpha[1], alpha[0]};
         default: word_val = $urandom;
      endcase
      case (shape)
         PH_WIDE: width_val = 9'd511;
         PH_FULL: width_val = 9'd256;
         default: width_val = ($urandom_range(0, 5) == 0) ? LINE_W'($urandom_range(0, 3))
                                                          : LINE_W'($urandom_range(4, 9));
      endcase
      mask = (shape == PH_SMALL) ? 2'($urandom_range(1, 3)) : 2'b11;
      load_regs(word_val, width_val, mask, $urandom_range(0, 7) == 0);
      if (mask[0]) cur_word = word_val;
      if (mask[1]) cur_width = width_val;
      for (int i = 0; i < 4; i++) alpha[i] = cur_word[8*i +: 8];
      alpha[4] = (mask[0] && kind == 1) ? alpha[0] : CH_W'($urandom_range(0, 255));
      w_eff = (cur_width < 4) ? 4 : (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
      if (shape == PH_WIDE) n_cells = MAX_WIDTH + $urandom_range(8, 40);
      else if (shape == PH_FULL || w_eff > 16) n_cells = $urandom_range(20, 60);
      else n_cells = $urandom_range(4, 6) * w_eff + $urandom_range(0, w_eff - 1);
      // without a fresh grid the old row position carries over into the new width
      fresh = (shape == PH_WIDE) || ($urandom_range(0, 4) != 0);
      gapless = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_cells; i++) begin
         pick = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(0, 255))
                                            : alpha[3'($urandom_range(0, 4))];
         send_cell(pick, (i == 0) ? fresh : ($urandom_range(0, 99) == 0));
         random_items++;
      end
   endtask

   initial begin : rsp_side
      int unsigned style;
      int unsigned span;
      int unsigned holds;
      holds = 0;
      forever begin
         style = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(posedge clock);
            // long hold-off so the result queue fills and the block stalls transfers
            if ((holds == 0 && sent_count >= 150) || (holds == 1 && sent_count >= 300)) begin
               rsp_ready <= 1'b0;
               repeat (80) @(posedge clock);
               holds++;
            end
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int unsigned phase_no;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // default word and width: one forward and one reverse hit on a row
      send_cell("X", 1'b1);
      send_cell("M", 1'b0);
      send_cell("A", 1'b0);
      send_cell("S", 1'b0);
      send_cell("A", 1'b0);
      send_cell("M", 1'b0);
      send_cell("X", 1'b0);

      // width below minimum, uniform word over a uniform grid
      settle();
      cur_word = 32'h4141_4141;
      cur_width = 9'd1;
      load_regs(cur_word, cur_width, 2'b11, 1'b0);
      for (int i = 0; i < 16; i++) send_cell("A", i == 0);

      phase_no = 0;
      while (random_items < 340) begin
         run_phase((phase_no == 2) ? PH_WIDE : PH_SMALL);
         phase_no++;
      end
      run_phase(PH_FULL);

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("** grid_word_search_counter: PASSED **");
      else
         $display("** grid_word_search_counter: FAILED **");
      $finish;
   end

endmodule

### grid_word_search_counter.f
rtl/gws_pkg.sv
rtl/gws_ram.sv
rtl/gws_front.sv
rtl/gws_core.sv
rtl/gws_fifo.sv
rtl/grid_word_search_counter.sv
rtl/gws_checker.sv
tb/gws_match_checker.sv
tb/tb_grid_word_search_counter.sv
